>>> hdl/gsch_pkg.sv
// gsch_pkg: shared constants, point and control types for the convex hull block
`timescale 1ns / 1ps
package gsch_pkg;

    localparam int MAX_POINTS = 64;
    localparam int COORD_BITS = 12;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int ACC_W      = 2 * DIFF_W + 2;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] y;
        logic signed [COORD_BITS-1:0] x;
    } point_t;

    typedef struct packed {
        logic en;
        logic load;
        logic neg;
    } mac_cmd_t;

    // coordinate difference at one extra bit, never overflows
    function automatic logic signed [DIFF_W-1:0] cdiff(
        input logic signed [COORD_BITS-1:0] a,
        input logic signed [COORD_BITS-1:0] b
    );
        logic signed [DIFF_W-1:0] ae;
        logic signed [DIFF_W-1:0] be;
        ae = DIFF_W'(a);
        be = DIFF_W'(b);
        return ae - be;
    endfunction

endpackage

>>> hdl/gsch_mac.sv
// gsch_mac: shared multiply-accumulate unit for cross products and squared distances
`timescale 1ns / 1ps
module gsch_mac (
    input  logic                                 aclk,
    input  gsch_pkg::mac_cmd_t                   cmd,
    input  logic signed [gsch_pkg::DIFF_W-1:0]   op_a,
    input  logic signed [gsch_pkg::DIFF_W-1:0]   op_b,
    output logic signed [gsch_pkg::ACC_W-1:0]    acc
);
    import gsch_pkg::*;

    logic signed [2*DIFF_W-1:0] prod;
    logic signed [ACC_W-1:0]    prod_ext;
    logic signed [ACC_W-1:0]    term;
    logic signed [ACC_W-1:0]    acc_reg;

    assign prod     = op_a * op_b;
    assign prod_ext = ACC_W'(prod);
    assign term     = cmd.neg ? -prod_ext : prod_ext;
    assign acc      = acc_reg;

    always_ff @(posedge aclk) begin
        if (cmd.en) begin
            acc_reg <= cmd.load ? term : acc_reg + term;
        end
    end

endmodule

>>> hdl/graham_scan_convex_hull.sv
// graham_scan_convex_hull: point loader, sequencer for pivot, sort, merge and scan
//
//  channel | dir | fields                                                | handshake
//  s_      | in  | point_x, point_y, last_point                           | s_valid/s_ready
//  m_      | out | hull_x, hull_y, no_hull, points_dropped, last_vertex   | m_valid/m_ready
//
// points load at one per cycle while s_ready is high; the item marked last starts the hull run
// the run finds the pivot, then runs the insertion sort (n^2/2 compares worst case), the
// merge and the scan with its pops, its pace set by the single point memory read port and
// the shared unit
// results leave one per accept, each read back from the stack; s_ready is low until the last one goes
// synchronous active-low reset clears the sequencer, counts and output valid
`timescale 1ns / 1ps
module graham_scan_convex_hull (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic signed [gsch_pkg::COORD_BITS-1:0] s_point_x,
    input  logic signed [gsch_pkg::COORD_BITS-1:0] s_point_y,
    input  logic                                   s_last_point,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [gsch_pkg::COORD_BITS-1:0] m_hull_x,
    output logic signed [gsch_pkg::COORD_BITS-1:0] m_hull_y,
    output logic                                   m_no_hull,
    output logic                                   m_points_dropped,
    output logic                                   m_last_vertex
);
    import gsch_pkg::*;

    localparam logic [4:0] S_LOAD   = 5'd0;
    localparam logic [4:0] S_PV_RD  = 5'd1;
    localparam logic [4:0] S_PV_EX  = 5'd2;
    localparam logic [4:0] S_SW_RD  = 5'd3;
    localparam logic [4:0] S_SW_WR  = 5'd4;
    localparam logic [4:0] S_SW_W0  = 5'd5;
    localparam logic [4:0] S_IS_RD  = 5'd6;
    localparam logic [4:0] S_IS_T   = 5'd7;
    localparam logic [4:0] S_IS_CHK = 5'd8;
    localparam logic [4:0] S_IS_D   = 5'd9;
    localparam logic [4:0] S_IS_BF1 = 5'd10;
    localparam logic [4:0] S_IS_BF2 = 5'd11;
    localparam logic [4:0] S_MG_RD  = 5'd12;
    localparam logic [4:0] S_MG_CUR = 5'd13;
    localparam logic [4:0] S_MG_CHK = 5'd14;
    localparam logic [4:0] S_MG_NX  = 5'd15;
    localparam logic [4:0] S_MG_TN  = 5'd16;
    localparam logic [4:0] S_SC_RD  = 5'd17;
    localparam logic [4:0] S_SC_CND = 5'd18;
    localparam logic [4:0] S_SC_CHK = 5'd19;
    localparam logic [4:0] S_SC_TN  = 5'd20;
    localparam logic [4:0] S_SC_SEC = 5'd21;
    localparam logic [4:0] S_OUT_RD = 5'd22;
    localparam logic [4:0] S_OUT_LD = 5'd23;
    localparam logic [4:0] S_OUT_W  = 5'd24;
    localparam logic [4:0] S_NH     = 5'd25;
    localparam logic [4:0] S_CALC   = 5'd26;

    localparam logic JOB_TURN = 1'b0;
    localparam logic JOB_DIST = 1'b1;

    // memories
    point_t pt_mem [MAX_POINTS];
    point_t stk_mem [MAX_POINTS];
    point_t pt_rdata_reg;
    point_t stk_rdata_reg;

    logic             pt_we;
    logic [IDX_W-1:0] pt_waddr;
    point_t           pt_wdata;
    logic [IDX_W-1:0] pt_raddr;
    logic             stk_we;
    logic [IDX_W-1:0] stk_waddr;
    logic [IDX_W-1:0] stk_raddr;

    // control and working registers
    logic [4:0]       state_reg;
    logic [4:0]       ret_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             ovf_reg;
    logic [CNT_W-1:0] i_reg;
    logic [CNT_W-1:0] j_reg;
    logic [CNT_W-1:0] m_reg;
    logic [CNT_W-1:0] sd_reg;
    logic [IDX_W-1:0] lo_reg;
    logic             job_reg;
    logic [1:0]       mstep_reg;
    logic             m_valid_reg;

    point_t piv_reg;
    point_t t_reg;
    point_t cur_reg;
    point_t nx_reg;
    point_t top_reg;
    point_t sec_reg;
    point_t p_reg;
    point_t q_reg;
    point_t r_reg;

    logic signed [COORD_BITS-1:0] hull_x_reg;
    logic signed [COORD_BITS-1:0] hull_y_reg;
    logic                         no_hull_reg;
    logic                         dropped_reg;
    logic                         last_reg;

    // shared unit
    mac_cmd_t                  mac_cmd;
    logic signed [DIFF_W-1:0]  op_a;
    logic signed [DIFF_W-1:0]  op_b;
    logic signed [ACC_W-1:0]   acc;
    logic                      acc_neg;
    logic                      acc_zero;
    logic                      calc_done;

    logic             s_fire;
    logic             has_room;
    logic [CNT_W-1:0] i_p1;
    logic [CNT_W-1:0] j_m1;
    logic [CNT_W-1:0] sd_m1;
    logic [CNT_W-1:0] sd_m3;
    logic             ap;
    logic             bp;
    logic             act;
    logic             bf;
    logic             push;
    point_t           in_pt;

    gsch_mac u_mac (
        .aclk (aclk),
        .cmd  (mac_cmd),
        .op_a (op_a),
        .op_b (op_b),
        .acc  (acc)
    );

    assign s_ready  = (state_reg == S_LOAD);
    assign s_fire   = s_valid && s_ready;
    assign has_room = (cnt_reg < CNT_W'(MAX_POINTS));
    assign i_p1     = i_reg + CNT_W'(1);
    assign j_m1     = j_reg - CNT_W'(1);
    assign sd_m1    = sd_reg - CNT_W'(1);
    assign sd_m3    = sd_reg - CNT_W'(3);
    assign acc_neg  = acc[ACC_W-1];
    assign acc_zero = (acc == '0);
    assign ap       = (t_reg == piv_reg);
    assign bp       = (pt_rdata_reg == piv_reg);
    assign in_pt    = '{y: s_point_y, x: s_point_x};
    assign calc_done = (job_reg == JOB_TURN) ? (mstep_reg == 2'd1) : (mstep_reg == 2'd3);

    assign m_valid          = m_valid_reg;
    assign m_hull_x         = hull_x_reg;
    assign m_hull_y         = hull_y_reg;
    assign m_no_hull        = no_hull_reg;
    assign m_points_dropped = dropped_reg;
    assign m_last_vertex    = last_reg;

    // sort decision and push decision
    always_comb begin
        act  = 1'b0;
        bf   = 1'b0;
        push = 1'b0;
        case (state_reg)
            S_IS_D: begin
                act = ap || bp;
                bf  = ap && !bp;
            end
            S_IS_BF1: begin
                act = !acc_zero;
                bf  = acc_neg;
            end
            S_IS_BF2: begin
                act = 1'b1;
                bf  = acc_neg;
            end
            S_SC_CHK: push = (i_reg < CNT_W'(3)) || (sd_reg < CNT_W'(2));
            S_SC_TN:  push = acc_neg;
            default: begin
                act  = 1'b0;
                bf   = 1'b0;
                push = 1'b0;
            end
        endcase
    end

    // operand select for the shared unit
    always_comb begin
        mac_cmd = '0;
        op_a    = '0;
        op_b    = '0;
        if (state_reg == S_CALC) begin
            mac_cmd.en   = 1'b1;
            mac_cmd.load = (mstep_reg == 2'd0);
            if (job_reg == JOB_TURN) begin
                mac_cmd.neg = (mstep_reg == 2'd1);
                if (mstep_reg == 2'd0) begin
                    op_a = cdiff(q_reg.y, p_reg.y);
                    op_b = cdiff(r_reg.x, q_reg.x);
                end else begin
                    op_a = cdiff(q_reg.x, p_reg.x);
                    op_b = cdiff(r_reg.y, q_reg.y);
                end
            end else begin
                mac_cmd.neg = mstep_reg[1];
                case (mstep_reg)
                    2'd0:    op_a = cdiff(q_reg.x, p_reg.x);
                    2'd1:    op_a = cdiff(q_reg.y, p_reg.y);
                    2'd2:    op_a = cdiff(r_reg.x, p_reg.x);
                    default: op_a = cdiff(r_reg.y, p_reg.y);
                endcase
                op_b = op_a;
            end
        end
    end

    // memory port select
    always_comb begin
        pt_we     = 1'b0;
        pt_waddr  = '0;
        pt_wdata  = cur_reg;
        pt_raddr  = '0;
        stk_we    = 1'b0;
        stk_waddr = sd_reg[IDX_W-1:0];
        stk_raddr = '0;
        case (state_reg)
            S_LOAD: begin
                pt_we    = s_fire && has_room;
                pt_waddr = cnt_reg[IDX_W-1:0];
                pt_wdata = in_pt;
            end
            S_PV_RD, S_IS_RD, S_MG_RD, S_SC_RD: pt_raddr = i_reg[IDX_W-1:0];
            S_SW_WR: begin
                pt_we    = 1'b1;
                pt_waddr = lo_reg;
                pt_wdata = pt_rdata_reg;
            end
            S_SW_W0: begin
                pt_we    = 1'b1;
                pt_wdata = piv_reg;
            end
            S_IS_CHK: begin
                if (j_reg <= CNT_W'(1)) begin
                    pt_we    = 1'b1;
                    pt_waddr = j_reg[IDX_W-1:0];
                    pt_wdata = t_reg;
                end else begin
                    pt_raddr = j_m1[IDX_W-1:0];
                end
            end
            // the neighbor is still on the read data here
            S_IS_D: begin
                pt_we    = act;
                pt_waddr = j_reg[IDX_W-1:0];
                pt_wdata = bf ? pt_rdata_reg : t_reg;
            end
            S_IS_BF1, S_IS_BF2: begin
                pt_we    = act;
                pt_waddr = j_reg[IDX_W-1:0];
                pt_wdata = bf ? cur_reg : t_reg;
            end
            S_MG_CHK: begin
                if (i_p1 < cnt_reg) begin
                    pt_raddr = i_p1[IDX_W-1:0];
                end else begin
                    pt_we    = 1'b1;
                    pt_waddr = m_reg[IDX_W-1:0];
                end
            end
            S_MG_TN: begin
                pt_we    = !acc_zero;
                pt_waddr = m_reg[IDX_W-1:0];
            end
            S_SC_CHK: stk_we = push;
            S_SC_TN: begin
                stk_we    = push;
                stk_raddr = sd_m3[IDX_W-1:0];
            end
            S_OUT_RD: stk_raddr = sd_m1[IDX_W-1:0];
            default: begin
                pt_we  = 1'b0;
                stk_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (pt_we) begin
            pt_mem[pt_waddr] <= pt_wdata;
        end
        pt_rdata_reg <= pt_mem[pt_raddr];
        if (stk_we) begin
            stk_mem[stk_waddr] <= cur_reg;
        end
        stk_rdata_reg <= stk_mem[stk_raddr];
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_LOAD;
            ret_reg     <= S_LOAD;
            cnt_reg     <= '0;
            ovf_reg     <= 1'b0;
            i_reg       <= '0;
            j_reg       <= '0;
            m_reg       <= '0;
            sd_reg      <= '0;
            lo_reg      <= '0;
            job_reg     <= JOB_TURN;
            mstep_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                S_LOAD: begin
                    if (s_fire) begin
                        if (has_room) begin
                            cnt_reg <= cnt_reg + CNT_W'(1);
                        end else begin
                            ovf_reg <= 1'b1;
                        end
                        if (s_last_point) begin
                            i_reg     <= '0;
                            state_reg <= S_PV_RD;
                        end
                    end
                end
                S_PV_RD: state_reg <= S_PV_EX;
                S_PV_EX: begin
                    if (i_reg == '0 || pt_rdata_reg.y < piv_reg.y ||
                        (pt_rdata_reg.y == piv_reg.y && pt_rdata_reg.x < piv_reg.x)) begin
                        lo_reg <= i_reg[IDX_W-1:0];
                    end
                    i_reg     <= i_p1;
                    state_reg <= (i_p1 < cnt_reg) ? S_PV_RD : S_SW_RD;
                end
                S_SW_RD: state_reg <= S_SW_WR;
                S_SW_WR: state_reg <= S_SW_W0;
                S_SW_W0: begin
                    i_reg     <= CNT_W'(2);
                    state_reg <= S_IS_RD;
                end
                S_IS_RD: begin
                    if (i_reg >= cnt_reg) begin
                        i_reg     <= CNT_W'(1);
                        m_reg     <= CNT_W'(1);
                        state_reg <= S_MG_RD;
                    end else begin
                        state_reg <= S_IS_T;
                    end
                end
                S_IS_T: begin
                    j_reg     <= i_reg;
                    state_reg <= S_IS_CHK;
                end
                S_IS_CHK: begin
                    if (j_reg <= CNT_W'(1)) begin
                        i_reg     <= i_p1;
                        state_reg <= S_IS_RD;
                    end else begin
                        state_reg <= S_IS_D;
                    end
                end
                S_IS_D, S_IS_BF1, S_IS_BF2: begin
                    if (act) begin
                        if (bf) begin
                            j_reg     <= j_m1;
                            state_reg <= S_IS_CHK;
                        end else begin
                            i_reg     <= i_p1;
                            state_reg <= S_IS_RD;
                        end
                    end else begin
                        // collinear or fresh compare: run the shared unit
                        job_reg   <= (state_reg == S_IS_D) ? JOB_TURN : JOB_DIST;
                        ret_reg   <= (state_reg == S_IS_D) ? S_IS_BF1 : S_IS_BF2;
                        state_reg <= S_CALC;
                    end
                end
                S_MG_RD: begin
                    if (i_reg >= cnt_reg) begin
                        if (m_reg < CNT_W'(3)) begin
                            state_reg <= S_NH;
                        end else begin
                            i_reg     <= '0;
                            sd_reg    <= '0;
                            state_reg <= S_SC_RD;
                        end
                    end else begin
                        state_reg <= S_MG_CUR;
                    end
                end
                S_MG_CUR: state_reg <= S_MG_CHK;
                S_MG_CHK: begin
                    if (i_p1 < cnt_reg) begin
                        state_reg <= S_MG_NX;
                    end else begin
                        m_reg     <= m_reg + CNT_W'(1);
                        i_reg     <= i_p1;
                        state_reg <= S_MG_RD;
                    end
                end
                S_MG_NX: begin
                    job_reg   <= JOB_TURN;
                    ret_reg   <= S_MG_TN;
                    state_reg <= S_CALC;
                end
                S_MG_TN: begin
                    i_reg <= i_p1;
                    if (acc_zero) begin
                        state_reg <= S_MG_CHK;
                    end else begin
                        m_reg     <= m_reg + CNT_W'(1);
                        state_reg <= S_MG_RD;
                    end
                end
                S_SC_RD: state_reg <= (i_reg >= m_reg) ? S_OUT_RD : S_SC_CND;
                S_SC_CND: state_reg <= S_SC_CHK;
                S_SC_CHK, S_SC_TN: begin
                    if (push) begin
                        sd_reg    <= sd_reg + CNT_W'(1);
                        i_reg     <= i_p1;
                        state_reg <= S_SC_RD;
                    end else if (state_reg == S_SC_CHK) begin
                        job_reg   <= JOB_TURN;
                        ret_reg   <= S_SC_TN;
                        state_reg <= S_CALC;
                    end else begin
                        // pop; refetch the new second entry when one exists
                        sd_reg    <= sd_m1;
                        state_reg <= (sd_reg >= CNT_W'(3)) ? S_SC_SEC : S_SC_CHK;
                    end
                end
                S_SC_SEC: state_reg <= S_SC_CHK;
                S_OUT_RD: state_reg <= S_OUT_LD;
                S_OUT_LD: begin
                    m_valid_reg <= 1'b1;
                    state_reg   <= S_OUT_W;
                end
                S_NH: begin
                    sd_reg      <= CNT_W'(1);
                    m_valid_reg <= 1'b1;
                    state_reg   <= S_OUT_W;
                end
                S_OUT_W: begin
                    if (m_ready) begin
                        m_valid_reg <= 1'b0;
                        sd_reg      <= sd_m1;
                        if (sd_reg == CNT_W'(1)) begin
                            cnt_reg   <= '0;
                            ovf_reg   <= 1'b0;
                            state_reg <= S_LOAD;
                        end else begin
                            state_reg <= S_OUT_RD;
                        end
                    end
                end
                S_CALC: begin
                    if (calc_done) begin
                        mstep_reg <= '0;
                        state_reg <= ret_reg;
                    end else begin
                        mstep_reg <= mstep_reg + 2'd1;
                    end
                end
                default: state_reg <= S_LOAD;
            endcase
        end
    end

    // working points and result payload
    always_ff @(posedge aclk) begin
        case (state_reg)
            S_PV_EX: begin
                if (i_reg == '0 || pt_rdata_reg.y < piv_reg.y ||
                    (pt_rdata_reg.y == piv_reg.y && pt_rdata_reg.x < piv_reg.x)) begin
                    piv_reg <= pt_rdata_reg;
                end
            end
            S_IS_T: t_reg <= pt_rdata_reg;
            S_IS_D: begin
                cur_reg <= pt_rdata_reg;
                p_reg   <= piv_reg;
                q_reg   <= t_reg;
                r_reg   <= pt_rdata_reg;
            end
            S_MG_CUR: cur_reg <= pt_rdata_reg;
            S_MG_NX: begin
                nx_reg <= pt_rdata_reg;
                p_reg  <= piv_reg;
                q_reg  <= cur_reg;
                r_reg  <= pt_rdata_reg;
            end
            S_MG_TN: begin
                if (acc_zero) begin
                    cur_reg <= nx_reg;
                end
            end
            S_SC_CND: cur_reg <= pt_rdata_reg;
            S_SC_CHK, S_SC_TN: begin
                if (push) begin
                    sec_reg <= top_reg;
                    top_reg <= cur_reg;
                end else if (state_reg == S_SC_CHK) begin
                    p_reg <= sec_reg;
                    q_reg <= top_reg;
                    r_reg <= cur_reg;
                end else begin
                    top_reg <= sec_reg;
                end
            end
            S_SC_SEC: sec_reg <= stk_rdata_reg;
            S_OUT_LD: begin
                hull_x_reg  <= stk_rdata_reg.x;
                hull_y_reg  <= stk_rdata_reg.y;
                no_hull_reg <= 1'b0;
                dropped_reg <= ovf_reg;
                last_reg    <= (sd_reg == CNT_W'(1));
            end
            S_NH: begin
                hull_x_reg  <= '0;
                hull_y_reg  <= '0;
                no_hull_reg <= 1'b1;
                dropped_reg <= ovf_reg;
                last_reg    <= 1'b1;
            end
            default: begin
            end
        endcase
    end

endmodule

>>> hdl/gsch_chk.sv
// gsch_chk: port-level checks for the convex hull block, bound to the top level
`timescale 1ns / 1ps
module gsch_chk (
    input logic                                   aclk,
    input logic                                   aresetn,
    input logic                                   s_valid,
    input logic                                   s_ready,
    input logic                                   s_last_point,
    input logic                                   m_valid,
    input logic                                   m_ready,
    input logic signed [gsch_pkg::COORD_BITS-1:0] m_hull_x,
    input logic                                   m_no_hull,
    input logic                                   m_last_vertex
);
    import gsch_pkg::*;

    // a stalled item holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_hull_x))
        else $error("result item changed while stalled");

    // loading and emitting never overlap
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input ready while a result is pending");

    // the last point starts the run and closes the input
    a_last_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_last_point |=> !s_ready)
        else $error("input still ready after last point");

    // a degenerate set gives exactly one item
    a_nohull_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_no_hull |-> m_last_vertex)
        else $error("no-hull item not marked last");

    // after the last vertex the block returns to loading
    a_last_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_last_vertex |=> !m_valid && s_ready)
        else $error("block not back to loading after last vertex");

endmodule

bind graham_scan_convex_hull gsch_chk u_gsch_chk (.*);
